@@ src/decision_diagram_node_store_defines.svh @@
// Assertion macros shared by the node store RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DECISION_DIAGRAM_NODE_STORE_DEFINES_SVH
`define DECISION_DIAGRAM_NODE_STORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DDNS_ASSERT_NOW(label, ck, rs, a, b) \
  label: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("node store check failed");

// Next-cycle implication, disabled in reset.
`define DDNS_ASSERT_NEXT(label, ck, rs, a, b) \
  label: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("node store check failed");

`endif

@@ src/ddns_pkg.sv @@
// Types and constants of the decision diagram node store.
// No dependencies; used by decision_diagram_node_store.
package ddns_pkg;

  localparam logic [63:0] MIX_CONSTANT = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned ROT_LEFT = 17;
  localparam logic [6:0] VAR_COUNT_RESET = 7'd64;
  localparam logic ACT_MAKE = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic        action;
    logic [5:0]  node_var;
    logic [13:0] low_child;
    logic [13:0] high_child;
    logic        high_complemented;
    logic [14:0] root_ref;
    logic [63:0] assignment;
  } item_t;

  typedef struct packed {
    logic [13:0] node_index;
    logic        found_existing;
    logic        table_full;
    logic        eval_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_HEAD_RD,
    ST_HEAD_TAKE,
    ST_CHAIN,
    ST_NODE_CMP,
    ST_APPEND,
    ST_EVAL,
    ST_EVAL_WAIT
  } state_t;

endpackage

@@ src/decision_diagram_node_store.sv @@
// Hash-consing node store for reduced ordered decision diagrams.
// Depends on ddns_pkg and decision_diagram_node_store_defines.svh.
//
// Usage:
//   Input channel: drive item and raise start; the beat is taken at a clock
//   edge where start is high and busy is low. One item is in work at a time.
//   Result channel: done pulses for exactly one cycle with result valid; the
//   receiver cannot stall, so the result must be captured in that cycle.
//   Config channel: cfg_data carries var_count, written when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high.
// Work per item, from accept to done:
//   redundant make_node or evaluate with zero var_count: done in the next cycle.
//   make_node: a hash step per field, the bucket reduction (low bits for
//   power-of-two buckets, else folds, a reciprocal estimate and a correction),
//   the bucket head read, a read and a compare per chain node visited, then
//   done on a match, or an end check and an append or refusal otherwise.
//   evaluate: a read and a check per internal node visited (up to var_count,
//   capped at VARIABLE_LIMIT); a node's variable past the limit stops the walk.
//   The single read port of the node memory sets the pace: each chain
//   or path step is a read followed by a compare. A new item may start in
//   the cycle where done is high.
// Reset: the bucket head memory is swept to zero, one entry per cycle, over
//   all BUCKET_COUNT entries; busy stays high meanwhile. Config writes are taken.
//   Node memory is not cleared; chain walks read only entries written since reset.
module decision_diagram_node_store #(
  parameter int NODE_COUNT     = 16384,
  parameter int BUCKET_COUNT   = 16384,
  parameter int VARIABLE_LIMIT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ddns_pkg::item_t   item,
  output logic              done,
  output ddns_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

`include "decision_diagram_node_store_defines.svh"

  localparam int NAW = $clog2(NODE_COUNT);
  localparam int BAW = $clog2(BUCKET_COUNT);
  localparam bit BUCKET_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
  // Bucket reduction for other counts: fold the top word by 2^32 mod count,
  // then take a reciprocal quotient estimate and correct it once.
  localparam longint unsigned FOLD_MUL  = (64'd1 << 32) % BUCKET_COUNT;
  localparam int              MOD_SHIFT = 32 + BAW;
  localparam longint unsigned RECIP     = (64'd1 << MOD_SHIFT) / BUCKET_COUNT;

  typedef struct packed {
    logic [5:0]     var_id;
    logic [13:0]    lo;
    logic [13:0]    hi;
    logic           inv;
    logic [NAW-1:0] chain;
  } node_t;

  // Storage: node entries and bucket chain heads.
  node_t          node_mem   [NODE_COUNT];
  logic [NAW-1:0] bucket_mem [BUCKET_COUNT];

  ddns_pkg::state_t state, state_next;

  ddns_pkg::item_t  req;
  logic [6:0]       var_count;
  logic [6:0]       eval_limit;
  logic [NAW:0]     nodes_used;
  logic [BAW-1:0]   clr_addr;
  logic [63:0]      h;
  logic [1:0]       hcnt;
  logic [5:0]       mod_cnt;
  logic [64:0]      qprod;
  logic [32:0]      rem_est;
  logic [BAW-1:0]   bucket;
  logic [NAW-1:0]   head;
  logic [NAW-1:0]   cur;
  logic [13:0]      idx;
  logic             comp;
  logic [6:0]       steps;
  logic             oob;
  node_t            node_rd;
  logic [NAW-1:0]   bucket_rd;

  // Combinational control.
  logic             node_we;
  logic             bucket_we;
  logic [NAW-1:0]   node_raddr;
  logic [BAW-1:0]   bucket_waddr;
  logic [NAW-1:0]   bucket_wdata;
  logic             idx_oob;

  logic [13:0]      mul_op;
  logic [63:0]      prod;
  logic [63:0]      h_mix;
  logic [31:0]      quot;
  node_t            eval_entry;
  logic             node_match;
  logic             store_full;
  logic             redundant;
  logic [6:0]       limit_in;

  assign cfg_ready = 1'b1;

  // Hash datapath: one multiply per cycle.
  always_comb begin
    unique case (hcnt)
      2'd0:    mul_op = {8'd0, req.node_var};
      2'd1:    mul_op = req.low_child;
      2'd2:    mul_op = req.high_child;
      default: mul_op = {13'd0, req.high_complemented};
    endcase
    prod  = {50'd0, mul_op} * ddns_pkg::MIX_CONSTANT;
    h_mix = h ^ prod;
  end

  assign quot = 32'(qprod >> MOD_SHIFT);

  assign eval_entry = oob ? '0 : node_rd;
  assign idx_oob    = (32'(idx) >= NODE_COUNT);
  assign node_match = (node_rd.var_id == req.node_var) && (node_rd.lo == req.low_child) &&
                      (node_rd.hi == req.high_child) && (node_rd.inv == req.high_complemented);
  assign store_full = (nodes_used >= (NAW+1)'(NODE_COUNT));
  assign redundant  = (item.low_child == item.high_child) && !item.high_complemented;
  assign limit_in   = (var_count > 7'(VARIABLE_LIMIT)) ? 7'(VARIABLE_LIMIT) : var_count;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ddns_pkg::ST_CLEAR: begin
        if (clr_addr == BAW'(BUCKET_COUNT - 1)) state_next = ddns_pkg::ST_IDLE;
      end
      ddns_pkg::ST_IDLE: begin
        if (start) begin
          if (item.action == ddns_pkg::ACT_EVAL) begin
            if (limit_in != 7'd0) state_next = ddns_pkg::ST_EVAL;
          end else if (!redundant) begin
            state_next = ddns_pkg::ST_HASH;
          end
        end
      end
      ddns_pkg::ST_HASH: begin
        if (hcnt == 2'd3) state_next = ddns_pkg::ST_MOD;
      end
      ddns_pkg::ST_MOD: begin
        if (BUCKET_POW2 || mod_cnt == 6'd2) state_next = ddns_pkg::ST_HEAD_RD;
      end
      ddns_pkg::ST_HEAD_RD:   state_next = ddns_pkg::ST_HEAD_TAKE;
      ddns_pkg::ST_HEAD_TAKE: state_next = ddns_pkg::ST_CHAIN;
      ddns_pkg::ST_CHAIN: begin
        state_next = (cur == '0) ? ddns_pkg::ST_APPEND : ddns_pkg::ST_NODE_CMP;
      end
      ddns_pkg::ST_NODE_CMP: begin
        state_next = node_match ? ddns_pkg::ST_IDLE : ddns_pkg::ST_CHAIN;
      end
      ddns_pkg::ST_APPEND: state_next = ddns_pkg::ST_IDLE;
      ddns_pkg::ST_EVAL: begin
        state_next = (steps < eval_limit && idx > 14'd1) ? ddns_pkg::ST_EVAL_WAIT
                                                         : ddns_pkg::ST_IDLE;
      end
      ddns_pkg::ST_EVAL_WAIT: begin
        state_next = ({1'b0, eval_entry.var_id} >= eval_limit) ? ddns_pkg::ST_IDLE
                                                               : ddns_pkg::ST_EVAL;
      end
      default: state_next = ddns_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy         = (state != ddns_pkg::ST_IDLE);
    node_raddr   = (state == ddns_pkg::ST_EVAL) ? NAW'(idx) : cur;
    node_we      = (state == ddns_pkg::ST_APPEND) && !store_full;
    bucket_we    = (state == ddns_pkg::ST_CLEAR) || node_we;
    bucket_waddr = (state == ddns_pkg::ST_CLEAR) ? clr_addr : bucket;
    bucket_wdata = (state == ddns_pkg::ST_CLEAR) ? '0 : nodes_used[NAW-1:0];
  end

  // Memories: registered read.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[nodes_used[NAW-1:0]] <= '{var_id: req.node_var, lo: req.low_child,
                                         hi: req.high_child, inv: req.high_complemented,
                                         chain: head};
    end
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (bucket_we) bucket_mem[bucket_waddr] <= bucket_wdata;
    bucket_rd <= bucket_mem[bucket];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ddns_pkg::ST_CLEAR;
      clr_addr   <= '0;
      nodes_used <= (NAW+1)'(2);
      var_count  <= ddns_pkg::VAR_COUNT_RESET;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) var_count <= cfg_data;
      if (state == ddns_pkg::ST_CLEAR) clr_addr <= clr_addr + BAW'(1);
      if (node_we) nodes_used <= nodes_used + (NAW+1)'(1);
      priority if (state == ddns_pkg::ST_IDLE && start) begin
        done <= (item.action == ddns_pkg::ACT_EVAL) ? (limit_in == 7'd0) : redundant;
      end else if (state == ddns_pkg::ST_NODE_CMP && node_match) begin
        done <= 1'b1;
      end else if (state == ddns_pkg::ST_APPEND) begin
        done <= 1'b1;
      end else if (state != ddns_pkg::ST_CLEAR && state != ddns_pkg::ST_IDLE &&
                   state_next == ddns_pkg::ST_IDLE) begin
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ddns_pkg::ST_IDLE: begin
        if (start) begin
          req        <= item;
          h          <= ddns_pkg::MIX_CONSTANT;
          hcnt       <= 2'd0;
          mod_cnt    <= 6'd0;
          bucket     <= '0;
          eval_limit <= limit_in;
          idx        <= item.root_ref[14:1];
          comp       <= item.root_ref[0];
          steps      <= 7'd0;
          // A redundant test answers with its low child right away.
          result     <= '{node_index: (item.action == ddns_pkg::ACT_MAKE && redundant)
                                      ? item.low_child : 14'd0,
                          found_existing: 1'b0, table_full: 1'b0, eval_result: 1'b0};
        end
      end
      ddns_pkg::ST_HASH: begin
        // Mix one field: xor product, rotate except after the last.
        h    <= (hcnt == 2'd3) ? h_mix
                               : ((h_mix << ddns_pkg::ROT_LEFT) |
                                  (h_mix >> (64 - ddns_pkg::ROT_LEFT)));
        hcnt <= hcnt + 2'd1;
      end
      ddns_pkg::ST_MOD: begin
        if (BUCKET_POW2) begin
          bucket <= h[BAW-1:0];
        end else if (mod_cnt == 6'd0) begin
          // Fold the top word down until the hash fits in 32 bits.
          if (h[63:32] != 32'd0) begin
            h <= {32'd0, h[31:0]} + ({32'd0, h[63:32]} * FOLD_MUL);
          end else begin
            qprod   <= {33'd0, h[31:0]} * {1'b0, RECIP};
            mod_cnt <= 6'd1;
          end
        end else if (mod_cnt == 6'd1) begin
          // Quotient estimate is low by at most one.
          rem_est <= {1'b0, h[31:0]} - ({1'b0, quot} * 33'(BUCKET_COUNT));
          mod_cnt <= 6'd2;
        end else begin
          bucket <= (rem_est >= 33'(BUCKET_COUNT))
                    ? BAW'(rem_est - 33'(BUCKET_COUNT)) : BAW'(rem_est);
        end
      end
      ddns_pkg::ST_HEAD_TAKE: begin
        head <= bucket_rd;
        cur  <= bucket_rd;
      end
      ddns_pkg::ST_NODE_CMP: begin
        if (node_match) begin
          result <= '{node_index: 14'(cur), found_existing: 1'b1,
                      table_full: 1'b0, eval_result: 1'b0};
        end else begin
          cur <= node_rd.chain;
        end
      end
      ddns_pkg::ST_APPEND: begin
        if (store_full) begin
          result <= '{node_index: req.low_child, found_existing: 1'b0,
                      table_full: 1'b1, eval_result: 1'b0};
        end else begin
          result <= '{node_index: 14'(nodes_used), found_existing: 1'b0,
                      table_full: 1'b0, eval_result: 1'b0};
        end
      end
      ddns_pkg::ST_EVAL: begin
        oob <= idx_oob;
        if (!(steps < eval_limit && idx > 14'd1)) begin
          result.eval_result <= (idx <= 14'd1) ? (idx[0] ^ comp) : 1'b0;
        end
      end
      ddns_pkg::ST_EVAL_WAIT: begin
        if ({1'b0, eval_entry.var_id} >= eval_limit) begin
          result.eval_result <= 1'b0;
        end else if (req.assignment[eval_entry.var_id]) begin
          comp  <= comp ^ eval_entry.inv;
          idx   <= eval_entry.hi;
          steps <= steps + 7'd1;
        end else begin
          idx   <= eval_entry.lo;
          steps <= steps + 7'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks.
  `DDNS_ASSERT_NOW(a_used_range, clk, rst, 1'b1, nodes_used >= (NAW+1)'(2) && nodes_used <= (NAW+1)'(NODE_COUNT))
  `DDNS_ASSERT_NOW(a_flags_excl, clk, rst, done, !(result.found_existing && result.table_full))
  `DDNS_ASSERT_NEXT(a_accept_moves, clk, rst, start && !busy, busy || done)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for decision_diagram_node_store.
// Depends on ddns_pkg and the node store RTL; predicts every result in place.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES   = 16384;
  localparam int MAX_VAR = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ddns_pkg::item_t item = '0;
  logic done;
  ddns_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  always #1 clk = ~clk;

  decision_diagram_node_store u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the node store, bucket heads and variable count.
  logic [5:0]  shadow_var [NODES];
  logic [13:0] shadow_low [NODES];
  logic [13:0] shadow_high [NODES];
  logic        shadow_inv [NODES];
  logic [13:0] shadow_chain [NODES];
  logic [13:0] shadow_head [NODES];
  int unsigned shadow_used;
  logic [6:0]  shadow_var_count;

  // A node is walkable when every path below it ends at a terminal, so
  // evaluates started there never touch an entry that was not written.
  bit walkable [NODES];
  int walkable_list[$];

  ddns_pkg::result_t pending_results[$];
  int error_count = 0;
  int idle_pct = 0;

  function automatic logic [63:0] rotl17(logic [63:0] x);
    return {x[46:0], x[63:47]};
  endfunction

  function automatic bit walk_truth(logic [14:0] ref_in, logic [63:0] bits);
    int unsigned lim;
    logic [13:0] idx;
    logic comp;
    logic [5:0] v;
    lim = (shadow_var_count > 7'(MAX_VAR)) ? MAX_VAR : int'(shadow_var_count);
    idx = ref_in[14:1];
    comp = ref_in[0];
    if (lim == 0) return 1'b0;
    for (int step = 0; step < lim && idx > 1; step++) begin
      v = shadow_var[idx];
      if (v >= lim) return 1'b0;
      if (bits[v]) begin
        comp ^= shadow_inv[idx];
        idx = shadow_high[idx];
      end else begin
        idx = shadow_low[idx];
      end
    end
    if (idx > 1) return 1'b0;
    return idx[0] ^ comp;
  endfunction

  // Advance the shadow store by one accepted beat and return its result.
  function automatic ddns_pkg::result_t predict_node_store(ddns_pkg::item_t it);
    ddns_pkg::result_t r;
    logic [63:0] h;
    logic [13:0] bucket, cur;
    int walked;
    bit hit;
    r = '0;
    if (it.action == ddns_pkg::ACT_EVAL) begin
      r.eval_result = walk_truth(it.root_ref, it.assignment);
    end else if (it.low_child == it.high_child && !it.high_complemented) begin
      r.node_index = it.low_child;
    end else begin
      h = ddns_pkg::MIX_CONSTANT;
      h ^= 64'(it.node_var) * ddns_pkg::MIX_CONSTANT;
      h = rotl17(h);
      h ^= 64'(it.low_child) * ddns_pkg::MIX_CONSTANT;
      h = rotl17(h);
      h ^= 64'(it.high_child) * ddns_pkg::MIX_CONSTANT;
      h = rotl17(h);
      h ^= 64'(it.high_complemented) * ddns_pkg::MIX_CONSTANT;
      bucket = h[13:0];
      cur = shadow_head[bucket];
      walked = 0;
      hit = 0;
      while (cur != 0 && walked < NODES) begin
        if (shadow_var[cur] == it.node_var && shadow_low[cur] == it.low_child &&
            shadow_high[cur] == it.high_child &&
            shadow_inv[cur] == it.high_complemented) begin
          hit = 1;
          break;
        end
        cur = shadow_chain[cur];
        walked++;
      end
      if (hit) begin
        r.node_index = cur;
        r.found_existing = 1'b1;
      end else if (shadow_used >= NODES) begin
        r.node_index = it.low_child;
        r.table_full = 1'b1;
      end else begin
        cur = shadow_used[13:0];
        shadow_var[cur] = it.node_var;
        shadow_low[cur] = it.low_child;
        shadow_high[cur] = it.high_child;
        shadow_inv[cur] = it.high_complemented;
        shadow_chain[cur] = shadow_head[bucket];
        shadow_head[bucket] = cur;
        shadow_used++;
        r.node_index = cur;
        if (walkable[it.low_child] && walkable[it.high_child]) begin
          walkable[cur] = 1;
          walkable_list.push_back(int'(cur));
        end
      end
    end
    return r;
  endfunction

  // Send one beat, with a random gap in front when idling is enabled.
  task automatic send_item(ddns_pkg::item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_node_store(it));
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_var_count(logic [6:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_var_count = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic ddns_pkg::item_t noise_item();
    ddns_pkg::item_t it;
    it = ddns_pkg::item_t'({$urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic int pick_walkable();
    return walkable_list[$urandom_range(walkable_list.size() - 1)];
  endfunction

  // Build a make_node item over the given children; force a complement on equal children.
  function automatic ddns_pkg::item_t make_item(logic [5:0] v, int lo, int hi);
    ddns_pkg::item_t it;
    it = noise_item();
    it.action = ddns_pkg::ACT_MAKE;
    it.node_var = v;
    it.low_child = 14'(lo);
    it.high_child = 14'(hi);
    if (lo == hi) it.high_complemented = 1'b1;
    return it;
  endfunction

  function automatic ddns_pkg::item_t eval_item(int idx);
    ddns_pkg::item_t it;
    it = noise_item();
    it.action = ddns_pkg::ACT_EVAL;
    it.root_ref = {idx[13:0], 1'($urandom)};
    return it;
  endfunction

  task automatic test_directed();
    ddns_pkg::item_t it;
    int first, second;
    it = make_item(6'd0, 0, 1);
    it.high_complemented = 1'b0;
    send_item(it);                                   // fresh node
    send_item(it);                                   // same node again: found
    first = int'(shadow_used) - 1;
    it = make_item(6'd63, 1, 0);
    send_item(it);
    it = make_item(6'd5, 1, 1);
    it.high_complemented = 1'b0;
    send_item(it);                                   // redundant test collapses
    it.low_child = 14'h3FFF;
    it.high_child = 14'h3FFF;
    send_item(it);                                   // redundant at top index
    it = make_item(6'd0, 0, 0);                      // equal children, complemented
    send_item(it);
    it = make_item(6'd0, first, first);
    send_item(it);
    second = int'(shadow_used) - 1;
    for (int k = 0; k < 4; k++) send_item(eval_item(k % 2));
    it = eval_item(second);
    it.assignment = '0;
    send_item(it);
    it.assignment = '1;
    send_item(it);
    // Deep walk: two var-0 levels with one variable allowed reports false.
    write_var_count(7'd1);
    send_item(it);
    it = eval_item(int'(shadow_used) - 3);           // variable 63 above count
    send_item(it);
    write_var_count(7'd0);
    send_item(it);
    write_var_count(7'd127);
    send_item(it);
    send_item(eval_item(second));
    write_var_count(7'd64);
  endtask

  task automatic test_random(int count);
    ddns_pkg::item_t it;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        it = noise_item();
        it.action = ddns_pkg::ACT_MAKE;
      end else if (roll < 15) begin
        it = make_item(6'($urandom), 0, 0);
        it.low_child = 14'($urandom);
        it.high_child = it.low_child;
        it.high_complemented = 1'($urandom);
      end else if (roll < 50) begin
        // Lean on recent nodes so that paths grow deep.
        it = make_item(6'($urandom), pick_walkable(),
          $urandom_range(1) ? walkable_list[$] : pick_walkable());
      end else begin
        it = eval_item(pick_walkable());
      end
      send_item(it);
    end
  endtask

  // Compare each done beat with the oldest prediction.
  always @(posedge clk) begin
    ddns_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.node_index !== want.node_index)
          $display("%0t: node_index expected %0d actual %0d", $realtime,
            want.node_index, result.node_index);
        if (result.found_existing !== want.found_existing)
          $display("%0t: found_existing expected %0b actual %0b", $realtime,
            want.found_existing, result.found_existing);
        if (result.table_full !== want.table_full)
          $display("%0t: table_full expected %0b actual %0b", $realtime,
            want.table_full, result.table_full);
        if (result.eval_result !== want.eval_result)
          $display("%0t: eval_result expected %0b actual %0b", $realtime,
            want.eval_result, result.eval_result);
        if (result !== want) error_count++;
      end
    end
  end

  initial begin
    for (int k = 0; k < NODES; k++) begin
      shadow_head[k] = '0;
      walkable[k] = 0;
    end
    walkable[0] = 1;
    walkable[1] = 1;
    walkable_list = '{0, 1};
    shadow_used = 2;
    shadow_var_count = ddns_pkg::VAR_COUNT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    idle_pct = 0;
    test_random(500);
    write_var_count(7'($urandom_range(1, 63)));
    idle_pct = 53;
    test_random(500);
    write_var_count(7'd64);
    idle_pct = 20;
    test_random(500);
    write_var_count(7'd1);
    test_random(150);
    write_var_count(7'd127);
    idle_pct = 0;
    test_random(350);
    wait_results_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ decision_diagram_node_store.f @@
+incdir+src
src/ddns_pkg.sv
src/decision_diagram_node_store.sv
verif/testbench.sv
